FILE: design/pdg_pkg.sv
`default_nettype none
package pdg_pkg;
    localparam int MaxDimension = 16;
    localparam int ValueWidth = 32;
    localparam int SumWidth = 48;
    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_COEF = 2'd1;
    localparam logic [1:0] OP_BOUND = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;
    localparam logic [1:0] REG_DIMENSION = 2'd0;
    localparam logic [1:0] REG_TRIVIAL = 2'd1;
    localparam logic signed [SumWidth-1:0] S48_MAX = {1'b0, {(SumWidth-1){1'b1}}};
    localparam logic signed [SumWidth-1:0] S48_MIN = {1'b1, {(SumWidth-1){1'b0}}};

    // Control word shared by every cell in the row.
    typedef struct packed {
        logic add;
        logic clear;
        logic shift;
    } t_cell_ctl;

    // Saturating add of a quotient (at most 2^62 in magnitude) into a 48-bit sum.
    function automatic logic signed [SumWidth-1:0] add48(
        input logic signed [SumWidth-1:0] a, input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S48_MAX)) return S48_MAX;
        if (s < 65'(S48_MIN)) return S48_MIN;
        return s[SumWidth-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: design/pdg_div.sv
`default_nettype none
// Restoring divider: one quotient bit per cycle, floor(mag*2^shift/den) capped at 2^62.
module pdg_div
    import pdg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_mag,
    input  wire logic        i_shift32,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_num, r_rem, r_q, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy, r_sat;
    logic [64:0] rem_sh;
    logic        top, qb;
    logic [63:0] rem_nx;

    always_comb begin
        rem_sh = {r_rem, r_num[63]};
        top = rem_sh[64];
        qb = top || (rem_sh[63:0] >= r_den);
        rem_nx = qb ? (rem_sh[63:0] - r_den) : rem_sh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_mag;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_cnt  <= i_shift32 ? 7'd95 : 7'd79;
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_num <= {r_num[62:0], 1'b0};
                r_q   <= {r_q[62:0], qb};
                if (r_q[63:62] != 2'b00) r_sat <= 1'b1;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_sat || r_q > (64'd1 << 62)) ? (64'd1 << 62) : r_q;
endmodule
`default_nettype wire

FILE: design/pdg_cell.sv
`default_nettype none
// One dimension: holds row coefficient and gradient sum; the row word
// rotates toward cell 0 on each shift so the shared divider sees each in turn.
module pdg_cell
    import pdg_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cell_ctl                  i_ctl,
    input  wire logic                       i_row_we,
    input  wire logic [ValueWidth-1:0]      i_row_wd,
    input  wire logic [ValueWidth-1:0]      i_row_next,
    input  wire logic signed [SumWidth-1:0] i_grad_next,
    input  wire logic signed [63:0]         i_quot,
    output logic [ValueWidth-1:0]           o_row,
    output logic signed [SumWidth-1:0]      o_grad
);
    always_ff @(posedge i_clk) begin
        if (i_row_we) o_row <= i_row_wd;
        else if (i_ctl.shift) o_row <= i_row_next;
        if (!i_rst_n) o_grad <= '0;
        else if (i_ctl.clear) o_grad <= '0;
        else if (i_ctl.shift) o_grad <= i_ctl.add ? add48(i_grad_next, i_quot) : i_grad_next;
    end
endmodule
`default_nettype wire

FILE: design/polytope_distance_gradient.sv
`default_nettype none
// Channel  | Signals                               | Direction
// command  | i_start, o_busy, i_op, i_index, i_value | in
// result   | o_valid, o_gradient_value, o_component, o_last | out
// config   | i_cfg_we, i_cfg_index, i_cfg_data     | in
// A point beat does not hold busy; a coefficient beat holds it while S_MAC adds.
// A violated bound holds busy while each row entry inside the dimension, and then
// the excess, passes through a shared bit-serial divider (96 or 80 steps); cells
// beyond the dimension only rotate. Other bounds do not hold busy.
// Finish walks all MAX_DIMENSION cells, builds each product from slices of |g|,
// sends a beat for each of the first dimension cells, then clears the sums.
// Synchronous reset; results cannot be stalled.
module polytope_distance_gradient
    import pdg_pkg::*;
#(
    parameter int MAX_DIMENSION = MaxDimension
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_op,
    input  wire logic [3:0]        i_index,
    input  wire logic [31:0]       i_value,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [4:0]        i_cfg_data,
    output logic                   o_valid,
    output logic [31:0]            o_gradient_value,
    output logic [3:0]             o_component,
    output logic                   o_last
);
    localparam int N = MAX_DIMENSION;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIV_ROW, S_WAIT_ROW, S_DIV_EX,
                              S_WAIT_EX, S_EMIT} t_state;
    t_state r_state;

    logic [4:0] r_dim;
    logic r_triv;
    logic [ValueWidth-1:0] r_point [N];
    logic signed [63:0] r_dot, r_ex;
    logic [63:0] r_norm;
    logic signed [63:0] r_prod;
    logic [63:0] r_sq;
    logic [6:0] r_cnt;
    logic signed [SumWidth-1:0] r_dist;
    logic signed [SumWidth-1:0] r_g;
    logic r_gneg;
    logic [1:0] r_ph;
    logic [95:0] r_pacc;

    logic [6:0] eff;
    logic [IW-1:0] idx;
    logic [ValueWidth-1:0] row [N];
    logic signed [SumWidth-1:0] grad [N];
    t_cell_ctl ctl;
    logic row_we;
    logic div_start, div_done, div_sh;
    logic [63:0] div_mag, quot;
    logic signed [63:0] squot;
    logic acc;

    always_comb begin
        eff = (r_dim == 5'd0) ? 7'd1 : 7'(r_dim);
        if (eff > 7'(N)) eff = 7'(N);
    end

    // Only used once the index is known to be inside the dimension.
    assign idx = IW'(i_index);
    assign acc = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign row_we = acc && (i_op == OP_COEF) && ({3'b0, i_index} < eff);

    // Whole row rotates N times per facet; only cells below eff divide.
    logic in_dim;
    assign in_dim = ({1'b0, r_cnt} < {1'b0, eff});
    assign squot = row[0][31] ? -$signed(quot) : $signed(quot);
    always_comb begin
        ctl.clear = (r_state == S_EMIT) && (r_ph == 2'd3) && (r_cnt == 7'(N - 1));
        ctl.shift = ((r_state == S_WAIT_ROW) && div_done) ||
                    ((r_state == S_DIV_ROW) && !in_dim) ||
                    ((r_state == S_EMIT) && (r_ph == 2'd3));
        ctl.add = (r_state == S_WAIT_ROW);
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : gc
            logic [ValueWidth-1:0] rn;
            logic signed [SumWidth-1:0] gn;
            assign rn = (g == N - 1) ? row[0] : row[(g + 1) % N];
            assign gn = (g == N - 1) ? grad[0] : grad[(g + 1) % N];
            pdg_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                .i_row_we(row_we && (idx == IW'(g))),
                .i_row_wd(i_value), .i_row_next(rn),
                .i_grad_next(gn),
                .i_quot((g == N - 1) ? squot : 64'sd0),
                .o_row(row[g]), .o_grad(grad[g]));
        end
    endgenerate

    always_comb begin
        div_start = (r_state == S_DIV_ROW && in_dim) || (r_state == S_DIV_EX);
        div_sh = (r_state == S_DIV_ROW);
        if (r_state == S_DIV_EX) div_mag = r_ex;
        else div_mag = row[0][31] ? 64'(-$signed({row[0][31], row[0]}))
                                  : {32'b0, row[0]};
    end

    pdg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_mag(div_mag),
        .i_shift32(div_sh), .i_den(r_norm), .o_done(div_done), .o_quot(quot));

    // Excess of the facet, dot - bound*2^16 with saturation.
    logic signed [65:0] exw;
    assign exw = 66'(r_dot) - 66'($signed(i_value) * 64'sd65536);

    // Output product trunc(|g|*d/2^16)*2, saturated. The product is built from
    // three 16-bit slices of |g|, one slice per cycle.
    logic [47:0] mg, md;
    logic [15:0] mg_part;
    logic [63:0] pp;
    logic [79:0] pt;
    logic [33:0] pc;
    logic [31:0] res;
    always_comb begin
        mg = r_g[47] ? 48'(-r_g) : 48'(r_g);
        md = r_dist[47] ? 48'd0 : 48'(r_dist);
        case (r_ph)
            2'd0: mg_part = mg[15:0];
            2'd1: mg_part = mg[31:16];
            default: mg_part = mg[47:32];
        endcase
        pp = {48'd0, mg_part} * {16'd0, md};
        pt = r_pacc[95:16];
        pc = (pt > 80'h1_0000_0000) ? 34'h1_0000_0000 : pt[33:0];
        pc = {pc[32:0], 1'b0};
        if (r_gneg) res = (pc > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-pc);
        else res = (pc > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : pc[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dim <= 5'd16;
            r_triv <= 1'b0;
            r_dot <= '0;
            r_norm <= '0;
            r_dist <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DIMENSION[0:0]) r_dim <= i_cfg_data;
                else r_triv <= i_cfg_data[0];
            end
            case (r_state)
                S_IDLE: if (acc) begin
                    case (i_op)
                        OP_POINT: if ({3'b0, i_index} < eff)
                            r_point[idx] <= i_value;
                        OP_COEF: if ({3'b0, i_index} < eff) begin
                            r_prod <= $signed(r_point[idx]) * $signed(i_value);
                            r_sq <= 64'($signed(i_value) * $signed(i_value));
                            r_state <= S_MAC;
                        end
                        OP_BOUND: begin
                            if (exw > 66'sh7FFFFFFFFFFFFFFF) r_ex <= 64'h7FFFFFFFFFFFFFFF;
                            else if (exw < -66'sh8000000000000000)
                                r_ex <= 64'h8000000000000000;
                            else r_ex <= exw[63:0];
                            if (!(exw > 0) || r_norm == 0 ) begin
                                r_dot <= '0; r_norm <= '0;
                            end else begin
                                r_cnt <= '0;
                                r_state <= S_DIV_ROW;
                            end
                        end
                        default: begin
                            r_cnt <= '0;
                            r_ph <= 2'd0;
                            r_pacc <= '0;
                            r_dot <= '0; r_norm <= '0;
                            r_state <= S_EMIT;
                            r_g <= grad[0]; r_gneg <= grad[0][47];
                        end
                    endcase
                end
                S_MAC: begin
                    begin : mac
                        logic signed [64:0] ds;
                        logic [64:0] ns;
                        ds = 65'(r_dot) + 65'(r_prod);
                        ns = 65'(r_norm) + 65'(r_sq);
                        if (ds[64] != ds[63]) r_dot <= ds[64] ? 64'sh8000000000000000
                                                              : 64'sh7FFFFFFFFFFFFFFF;
                        else r_dot <= ds[63:0];
                        r_norm <= ns[64] ? '1 : ns[63:0];
                    end
                    r_state <= S_IDLE;
                end
                S_DIV_ROW: if (in_dim) r_state <= S_WAIT_ROW;
                    else begin
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'(N - 1)) r_state <= S_DIV_EX;
                    end
                S_WAIT_ROW: if (div_done) begin
                    r_cnt <= r_cnt + 7'd1;
                    r_state <= (r_cnt == 7'(N - 1)) ? S_DIV_EX : S_DIV_ROW;
                end
                S_DIV_EX: r_state <= S_WAIT_EX;
                S_WAIT_EX: if (div_done) begin
                    r_dist <= add48(r_dist, $signed(quot));
                    r_dot <= '0; r_norm <= '0;
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (r_ph != 2'd3) begin
                        r_pacc <= r_pacc + (96'(pp) << {r_ph, 4'd0});
                        r_ph <= r_ph + 2'd1;
                    end else begin
                        if (r_cnt < eff) begin
                            o_valid <= 1'b1;
                            o_gradient_value <= r_triv ? 32'd0 : res;
                            o_component <= r_cnt[3:0];
                            o_last <= (r_cnt + 7'd1 == eff);
                        end
                        r_pacc <= '0;
                        r_ph <= 2'd0;
                        r_g <= grad[1 % N]; r_gneg <= grad[1 % N][47];
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'(N - 1)) begin
                            r_dist <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_EMIT || $past(r_state) == S_EMIT) else $error("beat outside emit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ph == 2'd3 && r_cnt == 7'(N - 1)) |=> r_state == S_IDLE)
        else $error("emit overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_WAIT_ROW || r_state == S_WAIT_EX) else $error("stray divide");
endmodule
`default_nettype wire
